### design/assert_macros.svh
// Assertion macros used by the checker file mdp_check.sv.
// No dependencies; take it in by `include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle during reset.
`define ASSERT_SAME(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle rule");

// Next-cycle implication, idle during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle rule");

`endif

### design/mdp_pkg.sv
// Shared types and constants for the minimum-deletions palindrome block.
// No dependencies; used by mdp_front, mdp_queue, mdp_back and the top level.
package mdp_pkg;

  // Fixed-width carriers sized for the largest supported MAX_LEN (1024).
  typedef logic [9:0]  addr_t;
  typedef logic [10:0] len_t;

  localparam logic [5:0] DEL_MAX   = 6'd63;
  localparam len_t       DEL_LIMIT = 11'd63;

  // Character store write from the front end.
  typedef struct packed {
    logic       we;
    addr_t      addr;
    logic [7:0] data;
  } char_wr_t;

  // One finished string handed to the back end.
  typedef struct packed {
    len_t len;
    logic ovf;
  } job_t;

  // Result transaction from the back end.
  typedef struct packed {
    logic       done;
    logic [5:0] deletions;
    logic       too_long;
  } result_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROW,
    B_CI,
    B_STEP,
    B_DONE
  } back_state_t;

endpackage

### design/mdp_front.sv
// Front end: accepts characters, writes them to the character store and
// hands a job descriptor to the queue on the last character. Uses mdp_pkg.
module mdp_front #(
  parameter int MAX_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        char_byte,
  input  logic              last,
  output mdp_pkg::char_wr_t char_wr,
  output logic              push,
  output mdp_pkg::job_t     job
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] cnt;
  logic [CW-1:0] cnt_next;
  logic          ovf;
  logic          ovf_next;
  logic          has_room;
  logic [CW-1:0] len_now;
  logic          ovf_now;

  assign has_room = (cnt < CW'(MAX_LEN));
  assign len_now  = has_room ? (cnt + CW'(1)) : cnt;
  assign ovf_now  = ovf | ~has_room;

  always_comb begin
    char_wr.we   = accept & has_room;
    char_wr.addr = mdp_pkg::addr_t'(cnt[AW-1:0]);
    char_wr.data = char_byte;
    push         = accept & last;
    job.len      = mdp_pkg::len_t'(len_now);
    job.ovf      = ovf_now;
  end

  always_comb begin
    cnt_next = cnt;
    ovf_next = ovf;
    if (accept) begin
      if (last) begin
        cnt_next = '0;
        ovf_next = 1'b0;
      end else begin
        cnt_next = len_now;
        ovf_next = ovf_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      ovf <= 1'b0;
    end else begin
      cnt <= cnt_next;
      ovf <= ovf_next;
    end
  end

endmodule

### design/mdp_queue.sv
// Two-entry job queue between front and back end.
// Uses mdp_pkg::job_t.
module mdp_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mdp_pkg::job_t push_job,
  input  logic          pop,
  output mdp_pkg::job_t head,
  output logic          empty,
  output logic          full
);

  mdp_pkg::job_t slots [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    count;

  logic do_push;
  logic do_pop;

  assign empty   = (count == 2'd0);
  assign full    = (count == 2'd2);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### design/mdp_back.sv
// Back end: sweeps the interval program over one stored string, one cell
// per cycle but for row setup; uses char store, working row and mdp_pkg.
module mdp_back #(
  parameter int MAX_LEN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  mdp_pkg::char_wr_t char_wr,
  input  mdp_pkg::job_t     job,
  input  logic              job_valid,
  output logic              pop,
  output logic              active,
  output mdp_pkg::result_t  result
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW = AW;
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [7:0]    char_mem [MAX_LEN];
  logic [DW-1:0] dp_mem   [MAX_LEN];
  logic [7:0]    ch_q;
  logic [DW-1:0] dp_q;

  mdp_pkg::back_state_t state;
  mdp_pkg::back_state_t state_next;

  logic [CW-1:0] len;
  logic          ovf;
  logic [AW-1:0] i_idx;
  logic [AW-1:0] j_idx;
  logic [7:0]    ci;
  logic [DW-1:0] diag;
  logic [DW-1:0] left_val;
  logic [DW-1:0] res;

  logic [CW-1:0] len_m1;
  logic [AW-1:0] last_idx;
  logic [AW-1:0] rd_addr;
  logic          dp_we;
  logic [AW-1:0] dp_waddr;
  logic [DW-1:0] dp_wdata;
  logic          row_end;
  logic [DW-1:0] mn;
  logic [DW-1:0] step_val;
  logic [CW-1:0] job_len;

  assign job_len  = job.len[CW-1:0];
  assign len_m1   = len - CW'(1);
  assign last_idx = len_m1[AW-1:0];
  assign mn       = (dp_q < left_val) ? dp_q : left_val;
  assign step_val = (ci == ch_q) ? diag : (mn + DW'(1));

  // Memories: one write port each, registered read at a shared address.
  always_ff @(posedge clk) begin
    if (char_wr.we) begin
      char_mem[char_wr.addr[AW-1:0]] <= char_wr.data;
    end
    ch_q <= char_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (dp_we) begin
      dp_mem[dp_waddr] <= dp_wdata;
    end
    dp_q <= dp_mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      mdp_pkg::B_IDLE: begin
        if (job_valid) begin
          state_next = job.ovf ? mdp_pkg::B_DONE : mdp_pkg::B_ROW;
        end
      end
      mdp_pkg::B_ROW: state_next = mdp_pkg::B_CI;
      mdp_pkg::B_CI, mdp_pkg::B_STEP: begin
        if (row_end) begin
          state_next = (i_idx == '0) ? mdp_pkg::B_DONE : mdp_pkg::B_ROW;
        end else begin
          state_next = mdp_pkg::B_STEP;
        end
      end
      mdp_pkg::B_DONE: state_next = mdp_pkg::B_IDLE;
      default:         state_next = mdp_pkg::B_IDLE;
    endcase
  end

  // Outputs and memory controls.
  always_comb begin
    pop      = 1'b0;
    rd_addr  = i_idx;
    dp_we    = 1'b0;
    dp_waddr = i_idx;
    dp_wdata = '0;
    row_end  = 1'b0;
    unique case (state)
      mdp_pkg::B_IDLE: pop = job_valid;
      mdp_pkg::B_ROW:  rd_addr = i_idx;
      mdp_pkg::B_CI: begin
        dp_we    = 1'b1;
        dp_waddr = i_idx;
        row_end  = (i_idx == last_idx);
        rd_addr  = i_idx + AW'(1);
      end
      mdp_pkg::B_STEP: begin
        dp_we    = 1'b1;
        dp_waddr = j_idx;
        dp_wdata = step_val;
        row_end  = (j_idx == last_idx);
        rd_addr  = j_idx + AW'(1);
      end
      mdp_pkg::B_DONE: rd_addr = i_idx;
      default:         rd_addr = i_idx;
    endcase
  end

  always_comb begin
    mdp_pkg::len_t res_ext;
    res_ext          = mdp_pkg::len_t'(res);
    active           = (state != mdp_pkg::B_IDLE);
    result.done      = (state == mdp_pkg::B_DONE);
    result.too_long  = ovf;
    if (ovf || (res_ext > mdp_pkg::DEL_LIMIT)) begin
      result.deletions = mdp_pkg::DEL_MAX;
    end else begin
      result.deletions = res_ext[5:0];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      mdp_pkg::B_IDLE: begin
        if (job_valid) begin
          len   <= job_len;
          ovf   <= job.ovf;
          i_idx <= AW'(job_len - CW'(1));
        end
      end
      mdp_pkg::B_CI: begin
        ci       <= ch_q;
        diag     <= '0;
        left_val <= '0;
        j_idx    <= i_idx + AW'(1);
        if (i_idx == last_idx) begin
          res <= '0;
        end
        if (row_end) begin
          i_idx <= i_idx - AW'(1);
        end
      end
      mdp_pkg::B_STEP: begin
        diag     <= dp_q;
        left_val <= step_val;
        j_idx    <= j_idx + AW'(1);
        if (row_end) begin
          res   <= step_val;
          i_idx <= i_idx - AW'(1);
        end
      end
      default: begin
        ci <= ci;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdp_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### design/min_deletions_to_palindrome.sv
// Characters are accepted one per cycle while busy is low; the last one queues a
// descriptor that the back end pops and sweeps row by row before done rises.
// One string at a time: busy rises once that descriptor is queued and holds
// through the strobe cycle, and the result never waits.
// Synchronous active-high reset clears the counters, the job queue and the
// sequencer; stores need no reset. Uses mdp_pkg, mdp_front, mdp_queue, mdp_back.
module min_deletions_to_palindrome #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] char_byte,
  input  logic       last,
  output logic       done,
  output logic [5:0] deletions,
  output logic       too_long
);

  // Front end writes characters; the back end holds the stores and sweeps.
  // The queue carries one descriptor per finished string (length, overflow).
  mdp_pkg::char_wr_t char_wr;
  mdp_pkg::job_t     push_job;
  mdp_pkg::job_t     head_job;
  mdp_pkg::result_t  result;

  logic accept;
  logic push;
  logic pop;
  logic q_empty;
  logic q_full;
  logic back_active;

  // Hold off new transactions while a string is queued or being swept,
  // since the character store is shared by both ends.
  assign busy   = ~q_empty | back_active | q_full;
  assign accept = start & ~busy;

  mdp_front #(
    .MAX_LEN (MAX_LEN)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_byte (char_byte),
    .last      (last),
    .char_wr   (char_wr),
    .push      (push),
    .job       (push_job)
  );

  mdp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  mdp_back #(
    .MAX_LEN (MAX_LEN)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .char_wr   (char_wr),
    .job       (head_job),
    .job_valid (~q_empty),
    .pop       (pop),
    .active    (back_active),
    .result    (result)
  );

  // Drive the result transaction straight from the back end's state.
  assign done      = result.done;
  assign deletions = result.deletions;
  assign too_long  = result.too_long;

endmodule

### design/mdp_check.sv
// Port-level checker for the minimum-deletions palindrome block, bound to
// the top level. Depends on assert_macros.svh.
`include "assert_macros.svh"

module mdp_check (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       last,
  input logic       done,
  input logic [5:0] deletions,
  input logic       too_long
);

  `ASSERT_NEXT(a_done_one_cycle, clk, rst, done, !done)
  `ASSERT_NEXT(a_last_sets_busy, clk, rst, start && !busy && last, busy)
  `ASSERT_SAME(a_too_long_sat, clk, rst, done && too_long, deletions == 6'd63)
  `ASSERT_SAME(a_done_while_busy, clk, rst, done, busy)
  `ASSERT_NEXT(a_no_done_after_accept, clk, rst, start && !busy, !done)

endmodule

bind min_deletions_to_palindrome mdp_check u_mdp_check (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .last      (last),
  .done      (done),
  .deletions (deletions),
  .too_long  (too_long)
);
